@@ rtl/chip8_quirk_instruction_unit_macros.svh @@
// Assertion macros used by the checker file of the quirk instruction unit.
`ifndef CHIP8_QUIRK_INSTRUCTION_UNIT_MACROS_SVH
`define CHIP8_QUIRK_INSTRUCTION_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define C8Q_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define C8Q_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/chip8q_pkg.sv @@
// Types and constants shared by the quirk instruction unit modules.
`default_nettype none
package chip8q_pkg;

	// Input item selector codes.
	localparam logic [2:0] OP_EXEC   = 3'd0;
	localparam logic [2:0] OP_SETV   = 3'd1;
	localparam logic [2:0] OP_SETI   = 3'd2;
	localparam logic [2:0] OP_MWRITE = 3'd3;
	localparam logic [2:0] OP_MREAD  = 3'd4;

	localparam int unsigned IN_TDATA_W  = 48;
	localparam int unsigned OUT_TDATA_W = 48;

	localparam logic [3:0] VF_IDX   = 4'hF;
	localparam logic [3:0] V0_IDX   = 4'h0;
	localparam logic [3:0] TOP_ALU  = 4'h8;
	localparam logic [3:0] TOP_JUMP = 4'hB;
	localparam logic [3:0] TOP_MISC = 4'hF;
	localparam logic [3:0] ALU_OR   = 4'h1;
	localparam logic [3:0] ALU_AND  = 4'h2;
	localparam logic [3:0] ALU_XOR  = 4'h3;
	localparam logic [3:0] ALU_SHR  = 4'h6;
	localparam logic [3:0] ALU_SHL  = 4'hE;
	localparam logic [7:0] MISC_STORE = 8'h55;
	localparam logic [7:0] MISC_LOAD  = 8'h65;

	// Classified command kinds handed from the front end to the executor.
	typedef enum logic [3:0] {
		K_OR, K_AND, K_XOR, K_SHR, K_SHL, K_JUMP, K_STORE, K_LOAD,
		K_SETV, K_SETI, K_MWRITE, K_MREAD, K_NOP, K_UNH
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  x;     // VX, or the register of a register write
		logic [3:0]  y;
		logic [15:0] addr;  // NNN, new index or byte address
		logic [7:0]  data;
	} cmd_t;

	// Result fields, last member in the lowest bits.
	typedef struct packed {
		logic        unhandled;
		logic [7:0]  read_data;
		logic [7:0]  vf_after;
		logic [15:0] index_after;
		logic [12:0] pc_target;
		logic        pc_load;
	} result_t;

	typedef enum logic [3:0] {
		ES_CLEAR, ES_IDLE, ES_EXEC, ES_WRX, ES_WRF, ES_MOD,
		ES_MWR, ES_MRD, ES_STORE, ES_LOAD, ES_RESULT
	} exec_state_t;

endpackage
`default_nettype wire

@@ rtl/chip8q_front.sv @@
// Front end: accepts input transfers and classifies them into commands.
`default_nettype none
module chip8q_front
	import chip8q_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,
	input  wire logic [2:0]            s_axis_tuser,
	input  wire logic                  q_full,
	input  wire logic                  clearing,
	output logic                       q_push,
	output cmd_t                       q_cmd
);

	logic [15:0] instr;
	logic [3:0]  top;
	logic [3:0]  low;
	logic [7:0]  low8;
	kind_t       exec_kind;
	logic        seen_q;

	assign instr = s_axis_tdata[15:0];
	assign top   = instr[15:12];
	assign low   = instr[3:0];
	assign low8  = instr[7:0];

	always_comb begin
		exec_kind = K_UNH;
		unique case (top)
			TOP_ALU: begin
				unique case (low)
					ALU_OR:  exec_kind = K_OR;
					ALU_AND: exec_kind = K_AND;
					ALU_XOR: exec_kind = K_XOR;
					ALU_SHR: exec_kind = K_SHR;
					ALU_SHL: exec_kind = K_SHL;
					default: exec_kind = K_UNH;
				endcase
			end
			TOP_JUMP: exec_kind = K_JUMP;
			TOP_MISC: begin
				if (low8 == MISC_STORE) begin
					exec_kind = K_STORE;
				end else if (low8 == MISC_LOAD) begin
					exec_kind = K_LOAD;
				end
			end
			default: exec_kind = K_UNH;
		endcase
	end

	always_comb begin
		q_cmd.x    = instr[11:8];
		q_cmd.y    = instr[7:4];
		q_cmd.addr = {4'h0, instr[11:0]};
		q_cmd.data = s_axis_tdata[43:36];
		unique case (s_axis_tuser)
			OP_EXEC: q_cmd.kind = exec_kind;
			OP_SETV: begin
				q_cmd.kind = K_SETV;
				q_cmd.x    = s_axis_tdata[19:16];
			end
			OP_SETI: begin
				q_cmd.kind = K_SETI;
				q_cmd.addr = s_axis_tdata[35:20];
			end
			OP_MWRITE: begin
				q_cmd.kind = K_MWRITE;
				q_cmd.addr = s_axis_tdata[35:20];
			end
			OP_MREAD: begin
				q_cmd.kind = K_MREAD;
				q_cmd.addr = s_axis_tdata[35:20];
			end
			default: q_cmd.kind = K_NOP;
		endcase
	end

	// Nothing is taken until the first cycle after reset has passed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else begin
			seen_q <= 1'b1;
		end
	end

	assign s_axis_tready = seen_q & ~q_full & ~clearing;
	assign q_push        = s_axis_tvalid & s_axis_tready;

endmodule
`default_nettype wire

@@ rtl/chip8q_fifo.sv @@
// Two-entry command queue between the front end and the executor.
`default_nettype none
module chip8q_fifo
	import chip8q_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t din,
	output logic      full,
	input  wire logic pop,
	output logic      valid,
	output cmd_t      dout
);

	cmd_t       buf_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full    = (cnt_q == 2'd2);
	assign valid   = (cnt_q != 2'd0);
	assign dout    = buf_q[rp_q];
	assign do_push = push & ~full;
	assign do_pop  = pop & valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= ~wp_q;
			end
			if (do_pop) begin
				rp_q <= ~rp_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wp_q] <= din;
		end
	end

endmodule
`default_nettype wire

@@ rtl/chip8q_exec.sv @@
// Executor: register file, index register, byte memory and result register.
`default_nettype none
module chip8q_exec
	import chip8q_pkg::*;
#(
	parameter int unsigned MEMORY_BYTES = 4096
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   q_valid,
	input  wire cmd_t                   q_cmd,
	output logic                        q_pop,
	output logic                        clearing,
	output logic                        m_valid,
	input  wire logic                   m_ready,
	output result_t                     m_data
);

	localparam int unsigned AW = $clog2(MEMORY_BYTES);
	localparam logic [63:0] RECIP64 =
		((64'd1 << 32) + 64'(MEMORY_BYTES) - 64'd1) / 64'(MEMORY_BYTES);
	localparam int unsigned RW = $clog2(RECIP64 + 64'd1);
	localparam logic [RW-1:0] RECIP = RECIP64[RW-1:0];
	localparam int unsigned PW = 16 + RW;
	localparam logic [AW-1:0] LAST_ADDR = AW'(MEMORY_BYTES - 1);

	exec_state_t   state_q, state_d;
	cmd_t          cmd_q;
	logic [7:0]    vreg_q [16];
	logic [15:0]   index_q;
	logic [7:0]    mem [MEMORY_BYTES];
	logic [7:0]    rdata_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] maddr_q;
	logic [AW-1:0] maddr_nx;
	logic [3:0]    cnt_q;
	logic [3:0]    wcnt_q;
	logic          issued_q;
	logic          pend_q;
	logic [7:0]    vx_q;
	logic [7:0]    vy_q;
	logic [12:0]   target_q;
	logic [15:0]   modin_q;
	logic [PW-1:0] prod_q;
	logic [31:0]   qm;
	logic [31:0]   rem;
	logic          m_valid_q;
	result_t       res;

	logic          vr_we;
	logic [3:0]    vr_wa;
	logic [7:0]    vr_wd;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [7:0]    mem_wd;
	logic          mem_re;
	logic          out_load;
	logic [7:0]    alu_res;
	logic [7:0]    alu_flag;
	logic [15:0]   mod_in;

	assign q_pop   = (state_q == ES_IDLE) & q_valid;
	assign m_valid = m_valid_q;

	// VX result and VF flag of the logic and shift instructions.
	always_comb begin
		alu_res  = vx_q | vy_q;
		alu_flag = 8'h00;
		case (cmd_q.kind)
			K_AND: alu_res = vx_q & vy_q;
			K_XOR: alu_res = vx_q ^ vy_q;
			K_SHR: begin
				alu_res  = {1'b0, vy_q[7:1]};
				alu_flag = {7'd0, vy_q[0]};
			end
			K_SHL: begin
				alu_res  = {vy_q[6:0], 1'b0};
				alu_flag = {7'd0, vy_q[7]};
			end
			default: alu_res = vx_q | vy_q;
		endcase
	end

	// Address reduction modulo the memory size: quotient by reciprocal, then remainder.
	assign mod_in = ((cmd_q.kind == K_STORE) || (cmd_q.kind == K_LOAD)) ? index_q : cmd_q.addr;
	assign qm     = 32'(prod_q[PW-1:32]) * 32'(MEMORY_BYTES);
	assign rem    = 32'(modin_q) - qm;

	// The byte address follows I, and returns to zero when it passes the last memory byte or when I wraps past its top.
	assign maddr_nx = ((index_q == 16'hFFFF) || (maddr_q == LAST_ADDR)) ? '0 : maddr_q + 1'b1;

	always_comb begin
		state_d  = state_q;
		clearing = 1'b0;
		vr_we    = 1'b0;
		vr_wa    = cmd_q.x;
		vr_wd    = alu_res;
		mem_we   = 1'b0;
		mem_wa   = maddr_q;
		mem_wd   = cmd_q.data;
		mem_re   = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ES_CLEAR: begin
				clearing = 1'b1;
				mem_we   = 1'b1;
				mem_wa   = clr_q;
				mem_wd   = 8'h00;
				if (clr_q == LAST_ADDR) begin
					state_d = ES_IDLE;
				end
			end
			ES_IDLE: begin
				if (q_valid) begin
					state_d = ES_EXEC;
				end
			end
			ES_EXEC: begin
				case (cmd_q.kind) inside
					K_OR, K_AND, K_XOR, K_SHR, K_SHL: state_d = ES_WRX;
					K_STORE, K_LOAD, K_MWRITE, K_MREAD: state_d = ES_MOD;
					K_SETV: begin
						vr_we   = 1'b1;
						vr_wd   = cmd_q.data;
						state_d = ES_RESULT;
					end
					default: state_d = ES_RESULT;
				endcase
			end
			ES_WRX: begin
				vr_we   = 1'b1;
				state_d = ES_WRF;
			end
			ES_WRF: begin
				vr_we   = 1'b1;
				vr_wa   = VF_IDX;
				vr_wd   = alu_flag;
				state_d = ES_RESULT;
			end
			ES_MOD: begin
				case (cmd_q.kind)
					K_STORE:  state_d = ES_STORE;
					K_LOAD:   state_d = ES_LOAD;
					K_MWRITE: state_d = ES_MWR;
					default:  state_d = ES_MRD;
				endcase
			end
			ES_MWR: begin
				mem_we  = 1'b1;
				state_d = ES_RESULT;
			end
			ES_MRD: begin
				mem_re  = 1'b1;
				state_d = ES_RESULT;
			end
			ES_STORE: begin
				mem_we = 1'b1;
				mem_wd = vreg_q[cnt_q];
				if (cnt_q == cmd_q.x) begin
					state_d = ES_RESULT;
				end
			end
			ES_LOAD: begin
				mem_re = ~issued_q;
				vr_we  = pend_q;
				vr_wa  = wcnt_q;
				vr_wd  = rdata_q;
				if (pend_q && (wcnt_q == cmd_q.x)) begin
					state_d = ES_RESULT;
				end
			end
			ES_RESULT: begin
				if (!m_valid_q || m_ready) begin
					out_load = 1'b1;
					state_d  = ES_IDLE;
				end
			end
			default: state_d = ES_IDLE;
		endcase
	end

	always_comb begin
		res.pc_load     = (cmd_q.kind == K_JUMP);
		res.pc_target   = (cmd_q.kind == K_JUMP) ? target_q : 13'd0;
		res.index_after = index_q;
		res.vf_after    = vreg_q[VF_IDX];
		res.read_data   = (cmd_q.kind == K_MREAD) ? rdata_q : 8'h00;
		res.unhandled   = (cmd_q.kind == K_UNH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ES_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Control state and architectural registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			index_q   <= 16'h0000;
			cnt_q     <= 4'd0;
			wcnt_q    <= 4'd0;
			issued_q  <= 1'b0;
			pend_q    <= 1'b0;
			m_valid_q <= 1'b0;
			for (int i = 0; i < 16; i++) begin
				vreg_q[i] <= 8'h00;
			end
		end else begin
			if (state_q == ES_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (vr_we) begin
				vreg_q[vr_wa] <= vr_wd;
			end
			if ((state_q == ES_EXEC) && (cmd_q.kind == K_SETI)) begin
				index_q <= cmd_q.addr;
			end
			if (state_q == ES_MOD) begin
				cnt_q    <= 4'd0;
				wcnt_q   <= 4'd0;
				issued_q <= 1'b0;
				pend_q   <= 1'b0;
			end
			if (state_q == ES_STORE) begin
				cnt_q   <= cnt_q + 4'd1;
				index_q <= index_q + 16'd1;
			end
			if (state_q == ES_LOAD) begin
				pend_q <= ~issued_q;
				if (!issued_q) begin
					cnt_q   <= cnt_q + 4'd1;
					index_q <= index_q + 16'd1;
					if (cnt_q == cmd_q.x) begin
						issued_q <= 1'b1;
					end
				end
				if (pend_q) begin
					wcnt_q <= wcnt_q + 4'd1;
				end
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_ready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Working payload registers.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
		end
		if (state_q == ES_EXEC) begin
			vx_q     <= vreg_q[cmd_q.x];
			vy_q     <= vreg_q[cmd_q.y];
			target_q <= 13'(cmd_q.addr[11:0]) + 13'(vreg_q[V0_IDX]);
			modin_q  <= mod_in;
			prod_q   <= PW'(mod_in) * PW'(RECIP);
		end
		if (state_q == ES_MOD) begin
			maddr_q <= rem[AW-1:0];
		end else if ((state_q == ES_STORE) || ((state_q == ES_LOAD) && !issued_q)) begin
			maddr_q <= maddr_nx;
		end
		if (out_load) begin
			m_data <= res;
		end
	end

	// Single-port byte memory with registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_q <= mem[maddr_q];
		end
	end

endmodule
`default_nettype wire

@@ rtl/chip8_quirk_instruction_unit.sv @@
// Top level of the CHIP-8 quirk instruction unit.
// This unit executes the CHIP-8 instructions whose meaning differs between
// interpreters, with the original COSMAC behavior: 8XY1, 8XY2 and 8XY3 clear VF
// after the logic operation, 8XY6 and 8XYE shift VY into VX with the lost bit in
// VF, BNNN reports a jump to NNN plus V0, and FX55 and FX65 move V0 through VX
// to or from memory at I while advancing I once per byte. Side items set a V
// register or I and write or read one memory byte; every other instruction
// comes back flagged as unhandled. Each input transfer yields exactly one
// result transfer. A front end classifies items into a two-entry queue, and an
// executor works through them one at a time into an output register, so input
// transfers keep flowing while a result waits, until the queue is full. After
// reset the executor first zeroes the byte memory, one byte per cycle, and no
// input is taken during that pass. FX55 and FX65 move their bytes through the
// single memory port, one byte per cycle.
`default_nettype none
module chip8_quirk_instruction_unit
	import chip8q_pkg::*;
#(
	parameter int unsigned MEMORY_BYTES = 4096
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// instruction[15:0], reg_index[19:16], address[35:20], data[43:36], zero[47:44]
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// opcode[2:0]
	input  wire logic [2:0]             s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// pc_load[0], pc_target[13:1], index_after[29:14], vf_after[37:30],
	// read_data[45:38], unhandled[46], zero[47]
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

	logic    q_full;
	logic    q_push;
	logic    q_pop;
	logic    q_valid;
	logic    clearing;
	cmd_t    push_cmd;
	cmd_t    head_cmd;
	result_t result;

	chip8q_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_full        (q_full),
		.clearing      (clearing),
		.q_push        (q_push),
		.q_cmd         (push_cmd)
	);

	chip8q_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (push_cmd),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.dout   (head_cmd)
	);

	chip8q_exec #(
		.MEMORY_BYTES (MEMORY_BYTES)
	) u_exec (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_cmd    (head_cmd),
		.q_pop    (q_pop),
		.clearing (clearing),
		.m_valid  (m_axis_tvalid),
		.m_ready  (m_axis_tready),
		.m_data   (result)
	);

	// The result occupies the low 47 bits; the top bit pads to whole bytes.
	assign m_axis_tdata = {1'b0, result};

endmodule
`default_nettype wire

@@ rtl/chip8q_checker.sv @@
// Port-level checker for the quirk instruction unit, bound to the top level.
`default_nettype none
`include "chip8_quirk_instruction_unit_macros.svh"
module chip8q_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [47:0] s_axis_tdata,
	input wire logic [2:0]  s_axis_tuser,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [47:0] m_axis_tdata
);

	logic stalled;
	logic unused_in;

	assign stalled   = m_axis_tvalid & ~m_axis_tready;
	assign unused_in = s_axis_tvalid & s_axis_tready & (|s_axis_tdata) & (|s_axis_tuser);

	// A stalled result transfer stays offered.
	`C8Q_ASSERT_NEXT(a_out_hold, clk, arst_n, stalled, m_axis_tvalid, "result dropped while stalled")
	// A stalled result keeps its payload.
	`C8Q_ASSERT_NEXT(a_out_stable, clk, arst_n, stalled, $stable(m_axis_tdata), "result changed while stalled")
	// Without a jump the target field is zero.
	`C8Q_ASSERT_IMPLY(a_no_target, clk, arst_n, m_axis_tvalid && !m_axis_tdata[0] && !unused_in, m_axis_tdata[13:1] == 13'd0, "target set without a jump")
	// A jump is always a handled instruction, and the pad bit stays clear.
	`C8Q_ASSERT_IMPLY(a_jump_handled, clk, arst_n, m_axis_tvalid, !(m_axis_tdata[0] && m_axis_tdata[46]) && !m_axis_tdata[47], "jump flagged unhandled")

endmodule

bind chip8_quirk_instruction_unit chip8q_checker u_chip8q_checker (.*);
`default_nettype wire
